/* hw/rtl/card_image_encoder_assert.svh */
// assertion macros for the card image encoder
`ifndef CARD_IMAGE_ENCODER_ASSERT_SVH
`define CARD_IMAGE_ENCODER_ASSERT_SVH

// same-cycle implication
`define CIE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cie same-cycle check failed");

// next-cycle implication
`define CIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cie next-cycle check failed");

`endif

/* hw/rtl/cie_pkg.sv */
package cie_pkg;

    localparam int CARD_COLUMNS = 80;
    localparam int PAIRS        = CARD_COLUMNS / 2;
    localparam int PAIR_W       = 6;
    localparam int COL_W        = 12;
    localparam int CHAR_W       = 8;
    localparam int ROWS         = 12;
    localparam int STEP_W       = 4;
    localparam int POS_W        = 7;
    localparam int NUM_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int DISP_LEN     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'b1;

    localparam logic [CHAR_W-1:0] FILLER    = 8'o377;
    localparam logic [CHAR_W-1:0] SPACE     = 8'o017;
    localparam logic [CHAR_W-1:0] DISP_CHAR = 8'o032;
    localparam logic [COL_W-1:0]  FULL_COL  = 12'hFFF;

    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);
    localparam logic [PAIR_W-1:0] MID_PAIR  = PAIR_W'(PAIRS / 2);
    localparam logic [NUM_W-1:0]  NUM_MAX   = {NUM_W{1'b1}};

    typedef logic [COL_W-1:0] t_col;

    // punch of one digit row, digit 0 is row 2
    function automatic t_col dg(input logic [3:0] d);
        return t_col'(12'd4 << d);
    endfunction

    function automatic t_col col_code(input logic [CHAR_W-1:0] ch);
        t_col       up;
        t_col       lo;
        logic [3:0] n;
        n = ch[3:0];
        unique case (ch[5:4])
            2'd0: up = '0;
            2'd1: up = 12'h005;
            2'd2: up = 12'h006;
            2'd3: up = 12'h003;
        endcase
        if (ch[7] | ch[6]) begin
            unique case (n)
                4'd3:    lo = dg(4'd3) | dg(4'd9) | dg(4'd2) | dg(4'd1) | dg(4'd0);
                4'd9:    lo = dg(4'd3) | dg(4'd9) | dg(4'd8) | dg(4'd0) | dg(4'd1);
                4'd10:   lo = dg(4'd3) | dg(4'd9) | dg(4'd8) | dg(4'd0) | dg(4'd2);
                4'd11:   lo = dg(4'd3) | dg(4'd9) | dg(4'd8) | dg(4'd2) | dg(4'd1);
                4'd12, 4'd13, 4'd14, 4'd15:
                         lo = dg(4'd3) | dg(4'd9) | dg(4'd8) | dg(4'd0) | dg(n - 4'd8);
                default: lo = dg(4'd3) | dg(4'd9) | dg(n);
            endcase
        end else if (n < 4'd10) begin
            lo = dg(n);
        end else begin
            lo = dg(4'd0) | dg(4'd8) | dg(n - 4'd8);
        end
        if (ch == FILLER || ch == SPACE) begin
            return '0;
        end
        return up ^ lo;
    endfunction

    function automatic logic [CHAR_W-1:0] odd_parity(input logic [CHAR_W-1:0] ch);
        if (^ch) begin
            return ch;
        end
        return ch | 8'h80;
    endfunction

endpackage

/* hw/rtl/cie_in_if.sv */
interface cie_in_if;
    logic                          valid;
    logic                          ready;
    logic [cie_pkg::CHAR_W-1:0]    card_char;
    logic                          end_of_card;

    modport source (output valid, card_char, end_of_card, input ready);
    modport sink   (input valid, card_char, end_of_card, output ready);
endinterface

/* hw/rtl/cie_out_if.sv */
interface cie_out_if;
    logic                          valid;
    logic                          ready;
    logic [2*cie_pkg::COL_W-1:0]   column_pair;
    logic [cie_pkg::PAIR_W-1:0]    pair_index;
    logic                          last_pair;

    modport source (output valid, column_pair, pair_index, last_pair, input ready);
    modport sink   (input valid, column_pair, pair_index, last_pair, output ready);
endinterface

/* hw/rtl/cie_cfg_if.sv */
interface cie_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cie_pkg::CFG_IDX_W-1:0]  index;
    logic [cie_pkg::NUM_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/card_image_encoder.sv */
// characters: one request per cycle while idle, stored in a single-port char store
// end of card: a setup state, then per pair a read and an accumulate state per char, then a load
// state; the dispatcher's end card has only the load state. Formats: rowwise card, column code card
// and dispatcher's end card; rate is set by the one read port of the char store feeding the one decode unit
// output register holds a pair until taken; the block is busy until the last pair loads
// synchronous active-low reset clears counters, card number, config and control state
`include "card_image_encoder_assert.svh"

module card_image_encoder #(
    parameter int CARD_CHARS = 120
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cie_in_if.sink       i_char,
    cie_cfg_if.sink      i_cfg,
    cie_out_if.source    o_pair
);

    localparam int AW = $clog2(CARD_CHARS);
    localparam int CW = $clog2(CARD_CHARS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_ACC,
        S_LOAD
    } t_state;

    typedef enum logic [1:0] {
        MODE_DISP,
        MODE_COL,
        MODE_ROW
    } t_mode;

    t_state                          r_state;
    t_mode                           r_mode;
    logic [cie_pkg::CHAR_W-1:0]      r_mem [CARD_CHARS];
    logic [cie_pkg::CHAR_W-1:0]      r_rd_data;
    logic                            r_rd_ok;
    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   r_fill_idx;
    logic                            r_fill_seen;
    logic                            r_pre_ok;
    logic [CW-1:0]                   r_limit;
    logic [cie_pkg::NUM_W-1:0]       r_card_num;
    logic [cie_pkg::NUM_W-1:0]       r_first;
    logic [cie_pkg::NUM_W-1:0]       r_last;
    logic [cie_pkg::PAIR_W-1:0]      r_pair;
    logic [cie_pkg::STEP_W-1:0]      r_step;
    cie_pkg::t_col                   r_even;
    cie_pkg::t_col                   r_odd;
    logic                            r_out_valid;
    logic [2*cie_pkg::COL_W-1:0]     r_out_data;
    logic [cie_pkg::PAIR_W-1:0]      r_out_idx;
    logic                            r_out_last;

    logic                            in_acc;
    logic                            store;
    logic [cie_pkg::POS_W-1:0]       pos;
    logic                            pos_ok;
    logic [cie_pkg::CHAR_W-1:0]      par;
    logic [1:0]                      row_bits;
    cie_pkg::t_col                   code;
    logic                            last_step;
    logic                            out_free;
    logic                            use_disp;
    logic                            use_col;

    assign i_char.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_char.valid && i_char.ready;
    assign store        = in_acc && (r_count < CW'(CARD_CHARS));
    assign out_free     = !r_out_valid || o_pair.ready;

    assign o_pair.valid       = r_out_valid;
    assign o_pair.column_pair = r_out_data;
    assign o_pair.pair_index  = r_out_idx;
    assign o_pair.last_pair   = r_out_last;

    // position of the char that feeds this step
    always_comb begin
        if (r_mode == MODE_COL) begin
            pos = cie_pkg::POS_W'({r_pair, 1'b0}) + cie_pkg::POS_W'(r_step);
        end else begin
            pos = (cie_pkg::POS_W'(r_step) << 3) + (cie_pkg::POS_W'(r_step) << 1)
                + cie_pkg::POS_W'(r_pair[cie_pkg::PAIR_W-1:2]);
        end
        pos_ok = ({1'b0, pos} < (cie_pkg::POS_W + 1)'(r_limit));
    end

    // shared decode unit
    always_comb begin
        par  = cie_pkg::odd_parity(r_rd_data);
        code = r_rd_ok ? cie_pkg::col_code(r_rd_data) : '0;
        unique case (r_pair[1:0])
            2'd0: row_bits = par[7:6];
            2'd1: row_bits = par[5:4];
            2'd2: row_bits = par[3:2];
            2'd3: row_bits = par[1:0];
        endcase
        last_step = (r_mode == MODE_COL) ? (r_step == cie_pkg::STEP_W'(1))
                                         : (r_step == cie_pkg::STEP_W'(cie_pkg::ROWS - 1));
    end

    assign use_disp = r_pre_ok && (r_count >= CW'(cie_pkg::DISP_LEN));
    assign use_col  = (r_first != '0) && (r_card_num >= r_first)
                   && ((r_last == '0) || (r_card_num <= r_last));

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[AW-1:0]] <= i_char.card_char;
        end
        if (r_state == S_READ && pos_ok) begin
            r_rd_data <= r_mem[pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_last  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cie_pkg::REG_FIRST: r_first <= i_cfg.data;
                cie_pkg::REG_LAST:  r_last  <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_ROW;
            r_count     <= '0;
            r_fill_idx  <= '0;
            r_fill_seen <= 1'b0;
            r_pre_ok    <= 1'b1;
            r_limit     <= '0;
            r_card_num  <= '0;
            r_pair      <= '0;
            r_step      <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_pair.ready && r_state != S_LOAD) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (store) begin
                        r_count <= r_count + CW'(1);
                        if (i_char.card_char == cie_pkg::FILLER && !r_fill_seen) begin
                            r_fill_seen <= 1'b1;
                            r_fill_idx  <= r_count;
                        end
                        if (r_count < CW'(cie_pkg::DISP_LEN)
                                && i_char.card_char != cie_pkg::DISP_CHAR) begin
                            r_pre_ok <= 1'b0;
                        end
                        if (r_count == CW'(cie_pkg::DISP_LEN)
                                && i_char.card_char != cie_pkg::FILLER) begin
                            r_pre_ok <= 1'b0;
                        end
                    end
                    if (in_acc && i_char.end_of_card) begin
                        if (r_card_num != cie_pkg::NUM_MAX) begin
                            r_card_num <= r_card_num + cie_pkg::NUM_W'(1);
                        end
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    // rowwise dump stops at the first filler, column code does not
                    r_limit     <= (r_fill_seen && !use_col) ? r_fill_idx : r_count;
                    r_count     <= '0;
                    r_fill_seen <= 1'b0;
                    r_pre_ok    <= 1'b1;
                    r_pair      <= '0;
                    r_step      <= '0;
                    r_even      <= '0;
                    r_odd       <= '0;
                    if (use_disp) begin
                        r_mode  <= MODE_DISP;
                        r_state <= S_LOAD;
                    end else begin
                        r_mode  <= use_col ? MODE_COL : MODE_ROW;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_ok <= pos_ok;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_mode == MODE_COL) begin
                        if (r_step == '0) begin
                            r_even <= code;
                        end else begin
                            r_odd <= code;
                        end
                    end else if (r_rd_ok) begin
                        if (row_bits[1]) begin
                            r_even[r_step] <= 1'b1;
                        end
                        if (row_bits[0]) begin
                            r_odd[r_step] <= 1'b1;
                        end
                    end
                    if (last_step) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_step  <= r_step + cie_pkg::STEP_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_pair;
                        r_out_last  <= (r_pair == cie_pkg::LAST_PAIR);
                        if (r_mode == MODE_DISP) begin
                            r_out_data <= (r_pair == '0 || r_pair == cie_pkg::MID_PAIR)
                                        ? {cie_pkg::FULL_COL, cie_pkg::t_col'(0)}
                                        : '0;
                        end else begin
                            r_out_data <= {r_even, r_odd};
                        end
                        r_even <= '0;
                        r_odd  <= '0;
                        r_step <= '0;
                        if (r_pair == cie_pkg::LAST_PAIR) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pair  <= r_pair + cie_pkg::PAIR_W'(1);
                            r_state <= (r_mode == MODE_DISP) ? S_LOAD : S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CIE_ASSERT_NEXT(a_eoc_busy, in_acc && i_char.end_of_card, !i_char.ready)
    `CIE_ASSERT_SAME(a_last_idx, r_out_valid, r_out_last == (r_out_idx == cie_pkg::LAST_PAIR))
    `CIE_ASSERT_SAME(a_count_cap, r_state != S_START, r_count <= CW'(CARD_CHARS))
    `CIE_ASSERT_NEXT(a_load_valid, r_state == S_LOAD && out_free, r_out_valid)

endmodule
